@@ rtl/csdd_pkg.sv @@
// Shared types, constants and code tables for the charstring decrypt decoder.
// Used by the front, queue, back and top-level modules.
package csdd_pkg;

    localparam logic [15:0] KEY_INIT = 16'd4330;
    localparam logic [15:0] KEY_MUL  = 16'd52845;
    localparam logic [15:0] KEY_ADD  = 16'd22719;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SKIP_RESET = 8'd4;

    // Register index on the configuration port
    localparam logic [0:0] REG_SKIP_COUNT = 1'b0;

    // Token kinds
    localparam logic [2:0] KIND_NUMBER  = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_ESCAPE  = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_END     = 3'd4;

    // Plain byte codes that start a multi-byte token
    localparam logic [7:0] CODE_ESCAPE = 8'd12;
    localparam logic [7:0] CODE_SHORT  = 8'd28;
    localparam logic [7:0] CODE_LONG   = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_POS,
        PH_NEG,
        PH_SHORT,
        PH_LONG,
        PH_ESC
    } csdd_phase_t;

    typedef struct packed {
        logic [7:0] cipher_byte;
        logic       string_start;
        logic       last_byte;
    } csdd_in_t;

    typedef struct packed {
        logic [2:0]         token_kind;
        logic signed [31:0] number_value;
        logic [7:0]         operator_code;
        logic               string_end;
    } csdd_out_t;

    // One queue entry: a plain byte to decode, or an end that fell on a dropped byte
    typedef struct packed {
        logic       empty_end;
        logic       clear;
        logic       last;
        logic [7:0] plain;
    } csdd_entry_t;

    function automatic logic single_known(input logic [7:0] b);
        return !(b == 8'd2 || b == 8'd15 || b == 8'd17);
    endfunction

    function automatic logic escape_known(input logic [7:0] c);
        logic known;
        known = !(c == 8'd19 || c == 8'd25 || c == 8'd31 || c == 8'd32);
        return (c <= 8'd37) && known;
    endfunction

endpackage

@@ rtl/csdd_front.sv @@
// Front end: charstring key decryption and leading-byte drop.
// Depends on csdd_pkg; feeds csdd_queue with plain bytes and end markers.
module csdd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            skip_count,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  csdd_pkg::csdd_in_t    byte_data,
    input  logic                  queue_full,
    output logic                  push,
    output csdd_pkg::csdd_entry_t push_entry
);
    import csdd_pkg::*;

    logic [15:0] key_reg;
    logic [15:0] key_next;
    logic [7:0]  skip_left_reg;
    logic [7:0]  skip_left_next;
    logic        clear_pend_reg;
    logic        clear_pend_next;

    logic [15:0] key_cur;
    logic [7:0]  skip_cur;
    logic [15:0] key_sum;
    logic [15:0] key_prod;
    logic        accept;
    logic        dropping;

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // A first mark restarts the key and the drop count before this byte is used
    assign key_cur  = byte_data.string_start ? KEY_INIT : key_reg;
    assign skip_cur = byte_data.string_start ? skip_count : skip_left_reg;
    assign dropping = (skip_cur != 8'd0);

    assign key_sum  = key_cur + {8'd0, byte_data.cipher_byte};
    assign key_prod = 16'(key_sum * KEY_MUL);
    assign key_next = key_prod + KEY_ADD;

    assign skip_left_next = dropping ? skip_cur - 8'd1 : skip_cur;

    assign push = accept && (!dropping || byte_data.last_byte);

    // Carry a pending decoder clear to the next entry that reaches the queue
    assign clear_pend_next = push ? 1'b0 : (clear_pend_reg || byte_data.string_start);

    always_comb
    begin
        push_entry.empty_end = dropping;
        push_entry.clear     = clear_pend_reg || byte_data.string_start;
        push_entry.last      = byte_data.last_byte;
        push_entry.plain     = byte_data.cipher_byte ^ key_cur[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg        <= KEY_INIT;
            skip_left_reg  <= 8'd0;
            clear_pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            key_reg        <= key_next;
            skip_left_reg  <= skip_left_next;
            clear_pend_reg <= clear_pend_next;
        end
    end

endmodule

@@ rtl/csdd_queue.sv @@
// Four-entry queue between the decrypting front end and the token decoder.
// Depends on csdd_pkg for the entry type and depth.
module csdd_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  csdd_pkg::csdd_entry_t push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output csdd_pkg::csdd_entry_t head_entry
);
    import csdd_pkg::*;

    csdd_entry_t         slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;

    assign full       = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

endmodule

@@ rtl/csdd_back.sv @@
// Back end: token decoder with a registered result stage.
// Depends on csdd_pkg; takes entries from csdd_queue.
module csdd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  csdd_pkg::csdd_entry_t head_entry,
    output logic                  pop,
    output logic                  token_valid,
    input  logic                  token_ready,
    output csdd_pkg::csdd_out_t   token_data
);
    import csdd_pkg::*;

    csdd_phase_t phase_reg;
    csdd_phase_t phase_next;
    logic [7:0]  prefix_reg;
    logic [7:0]  prefix_next;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    csdd_out_t   out_data_reg;

    // State after an optional clear carried by the entry
    csdd_phase_t phase_c;
    logic [7:0]  prefix_c;
    logic [31:0] acc_c;
    logic [2:0]  pend_c;

    logic [7:0]  b;
    logic [31:0] acc_shift;
    logic [2:0]  pend_dec;
    logic [31:0] pos_mag;
    logic [31:0] neg_mag;

    logic        dec_have;
    logic        res_have;
    csdd_out_t   res;

    assign pop = head_valid && (!out_valid_reg || token_ready);

    assign phase_c  = head_entry.clear ? PH_IDLE : phase_reg;
    assign prefix_c = head_entry.clear ? 8'd0 : prefix_reg;
    assign acc_c    = head_entry.clear ? 32'd0 : acc_reg;
    assign pend_c   = head_entry.clear ? 3'd0 : pend_reg;

    assign b         = head_entry.plain;
    assign acc_shift = {acc_c[23:0], b};
    assign pend_dec  = pend_c - 3'd1;
    assign pos_mag   = {22'd0, 2'(prefix_c - 8'd247), 8'd0} + 32'd108 + {24'd0, b};
    assign neg_mag   = {22'd0, 2'(prefix_c - 8'd251), 8'd0} + 32'd108 + {24'd0, b};

    // Result of this entry
    always_comb
    begin
        dec_have          = 1'b0;
        res.token_kind    = KIND_NUMBER;
        res.number_value  = 32'sd0;
        res.operator_code = 8'd0;
        res.string_end    = head_entry.last;
        if (!head_entry.empty_end)
        begin
            unique case (phase_c)
                PH_POS:
                begin
                    dec_have         = 1'b1;
                    res.number_value = signed'(pos_mag);
                end
                PH_NEG:
                begin
                    dec_have         = 1'b1;
                    res.number_value = signed'(32'd0 - neg_mag);
                end
                PH_SHORT:
                begin
                    if (pend_dec == 3'd0)
                    begin
                        dec_have         = 1'b1;
                        res.number_value = signed'({{16{acc_shift[15]}}, acc_shift[15:0]});
                    end
                end
                PH_LONG:
                begin
                    if (pend_dec == 3'd0)
                    begin
                        dec_have         = 1'b1;
                        res.number_value = signed'(acc_shift);
                    end
                end
                PH_ESC:
                begin
                    dec_have          = 1'b1;
                    res.token_kind    = escape_known(b) ? KIND_ESCAPE : KIND_UNKNOWN;
                    res.operator_code = b;
                end
                default:
                begin
                    if (b >= 8'd32 && b <= 8'd246)
                    begin
                        dec_have         = 1'b1;
                        res.number_value = signed'({24'd0, b} - 32'd139);
                    end
                    else if (b < 8'd32 && b != CODE_ESCAPE && b != CODE_SHORT)
                    begin
                        dec_have          = 1'b1;
                        res.token_kind    = single_known(b) ? KIND_OPERATOR : KIND_UNKNOWN;
                        res.operator_code = b;
                    end
                end
            endcase
        end
        // End on a dropped byte, or inside an unfinished token
        if (!dec_have && (head_entry.empty_end || head_entry.last))
        begin
            res.token_kind    = KIND_END;
            res.number_value  = 32'sd0;
            res.operator_code = 8'd0;
            res.string_end    = 1'b1;
        end
    end

    assign res_have = dec_have || head_entry.empty_end || head_entry.last;

    // Decoder state
    always_comb
    begin
        phase_next  = phase_c;
        prefix_next = prefix_c;
        acc_next    = acc_c;
        pend_next   = pend_c;
        if (!head_entry.empty_end)
        begin
            unique case (phase_c)
                PH_POS, PH_NEG, PH_ESC:
                begin
                    phase_next = PH_IDLE;
                end
                PH_SHORT, PH_LONG:
                begin
                    acc_next  = acc_shift;
                    pend_next = pend_dec;
                    if (pend_dec == 3'd0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    if (b >= 8'd247 && b <= 8'd250)
                    begin
                        prefix_next = b;
                        phase_next  = PH_POS;
                    end
                    else if (b >= 8'd251 && b <= 8'd254)
                    begin
                        prefix_next = b;
                        phase_next  = PH_NEG;
                    end
                    else if (b == CODE_LONG)
                    begin
                        acc_next   = 32'd0;
                        pend_next  = 3'd4;
                        phase_next = PH_LONG;
                    end
                    else if (b == CODE_SHORT)
                    begin
                        acc_next   = 32'd0;
                        pend_next  = 3'd2;
                        phase_next = PH_SHORT;
                    end
                    else if (b == CODE_ESCAPE)
                    begin
                        phase_next = PH_ESC;
                    end
                end
            endcase
            // Drop a partial token at the end of the string
            if (!dec_have && head_entry.last)
            begin
                phase_next = PH_IDLE;
                pend_next  = 3'd0;
                acc_next   = 32'd0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || token_ready)
        begin
            out_valid_next = pop && res_have;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            prefix_reg    <= 8'd0;
            acc_reg       <= 32'd0;
            pend_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg  <= phase_next;
                prefix_reg <= prefix_next;
                acc_reg    <= acc_next;
                pend_reg   <= pend_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && res_have)
        begin
            out_data_reg <= res;
        end
    end

    assign token_valid = out_valid_reg;
    assign token_data  = out_data_reg;

    a_end_kind_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_data.token_kind == KIND_END) |->
        (token_data.string_end && token_data.number_value == 32'sd0
         && token_data.operator_code == 8'd0))
        else $error("end result not closing or carries payload");

    a_value_only_numbers: assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_data.token_kind != KIND_NUMBER) |->
        (token_data.number_value == 32'sd0))
        else $error("number value set on a non-number result");

    a_multi_byte_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SHORT || phase_reg == PH_LONG) |-> (pend_reg != 3'd0))
        else $error("multi-byte number with nothing pending");

endmodule

@@ rtl/charstring_decrypt_decoder.sv @@
// A result goes through the queue and then the result register after the byte that completes its token is taken.
// Throughput: one byte per cycle while the queue is not full; the key update loop (16x16 multiply and add) sets it.
// A four-entry queue parts decryption from decoding; the result stage is a register.
// Reset: key 4330, skip_count 4, no bytes to drop, decoder waits for a token start.
// Top level: APB register, front end, queue and token decoder.
// Depends on csdd_pkg, csdd_front, csdd_queue and csdd_back.
module charstring_decrypt_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_ready,
    input  csdd_pkg::csdd_in_t  byte_data,
    output logic                token_valid,
    input  logic                token_ready,
    output csdd_pkg::csdd_out_t token_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import csdd_pkg::*;

    logic [7:0]  skip_count_reg;
    logic        cfg_write;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        head_valid;
    csdd_entry_t push_entry;
    csdd_entry_t head_entry;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SKIP_COUNT);
    assign prdata    = (paddr[2] == REG_SKIP_COUNT) ? {24'd0, skip_count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_count_reg <= SKIP_RESET;
        end
        else if (cfg_write)
        begin
            skip_count_reg <= pwdata[7:0];
        end
    end

    csdd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .skip_count (skip_count_reg),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .queue_full (queue_full),
        .push       (push),
        .push_entry (push_entry)
    );

    csdd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    csdd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data)
    );

endmodule

@@ tb/csdd_token_checker.sv @@
// Token checker for the charstring decrypt decoder: watches the byte, token and APB ports,
// predicts each token from the accepted bytes and compares it with what the block sends.
// Depends on csdd_pkg for the port types, token kinds, decode phases and key constants.
module csdd_token_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    input  logic                byte_ready,
    input  csdd_pkg::csdd_in_t  byte_data,
    input  logic                token_valid,
    input  logic                token_ready,
    input  csdd_pkg::csdd_out_t token_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  failures,
    output int                  pending
);
    import csdd_pkg::*;

    localparam logic [2:0] SKIP_ADDR = 3'({REG_SKIP_COUNT, 2'b00});

    logic [7:0]  skip_cfg;
    logic [15:0] key;
    logic [7:0]  drop_left;
    csdd_phase_t phase;
    logic [7:0]  lead;
    logic [31:0] acc;
    logic [2:0]  remaining;

    csdd_out_t expected_tokens[$];

    function automatic logic single_defined(input logic [7:0] code);
        case (code)
            8'd2, 8'd15, 8'd17: return 1'b0;
            default:            return 1'b1;
        endcase
    endfunction

    function automatic logic escape_defined(input logic [7:0] code);
        if (code > 8'd37)
            return 1'b0;
        case (code)
            8'd19, 8'd25, 8'd31, 8'd32: return 1'b0;
            default:                    return 1'b1;
        endcase
    endfunction

    function void queue_token(input logic [2:0] kind, input logic [31:0] value,
                              input logic [7:0] op, input logic fin);
        csdd_out_t tok;
        tok.token_kind    = kind;
        tok.number_value  = value;
        tok.operator_code = op;
        tok.string_end    = fin;
        expected_tokens.push_back(tok);
    endfunction

    // Decrypt one byte, advance the key and work out the token it closes, if any
    function void decode_byte(input csdd_in_t req);
        logic [7:0]  plain;
        logic [31:0] value;
        logic [2:0]  kind;
        logic [7:0]  op;
        logic        got;
        kind  = KIND_NUMBER;
        value = 32'd0;
        op    = 8'd0;
        got   = 1'b0;
        if (req.string_start)
        begin
            key       = KEY_INIT;
            drop_left = skip_cfg;
            phase     = PH_IDLE;
            lead      = 8'd0;
            acc       = 32'd0;
            remaining = 3'd0;
        end
        plain = req.cipher_byte ^ key[15:8];
        key   = ({8'd0, req.cipher_byte} + key) * KEY_MUL + KEY_ADD;

        if (drop_left != 8'd0)
        begin
            drop_left = drop_left - 8'd1;
            if (req.last_byte)
                queue_token(KIND_END, 32'd0, 8'd0, 1'b1);
            return;
        end

        case (phase)
            PH_POS:
            begin
                value = ({24'd0, lead} - 32'd247) * 32'd256 + 32'd108 + {24'd0, plain};
                got   = 1'b1;
                phase = PH_IDLE;
            end
            PH_NEG:
            begin
                value = 32'd0 - (({24'd0, lead} - 32'd251) * 32'd256 + 32'd108
                                 + {24'd0, plain});
                got   = 1'b1;
                phase = PH_IDLE;
            end
            PH_SHORT, PH_LONG:
            begin
                acc       = {acc[23:0], plain};
                remaining = remaining - 3'd1;
                if (remaining == 3'd0)
                begin
                    value = (phase == PH_SHORT) ? {{16{acc[15]}}, acc[15:0]} : acc;
                    got   = 1'b1;
                    phase = PH_IDLE;
                end
            end
            PH_ESC:
            begin
                kind  = escape_defined(plain) ? KIND_ESCAPE : KIND_UNKNOWN;
                op    = plain;
                got   = 1'b1;
                phase = PH_IDLE;
            end
            default:
            begin
                phase = PH_IDLE;
                if (plain >= 8'd32 && plain <= 8'd246)
                begin
                    value = {24'd0, plain} - 32'd139;
                    got   = 1'b1;
                end
                else if (plain >= 8'd247 && plain <= 8'd250)
                begin
                    lead  = plain;
                    phase = PH_POS;
                end
                else if (plain >= 8'd251 && plain != CODE_LONG)
                begin
                    lead  = plain;
                    phase = PH_NEG;
                end
                else if (plain == CODE_LONG)
                begin
                    acc       = 32'd0;
                    remaining = 3'd4;
                    phase     = PH_LONG;
                end
                else if (plain == CODE_SHORT)
                begin
                    acc       = 32'd0;
                    remaining = 3'd2;
                    phase     = PH_SHORT;
                end
                else if (plain == CODE_ESCAPE)
                    phase = PH_ESC;
                else
                begin
                    kind = single_defined(plain) ? KIND_OPERATOR : KIND_UNKNOWN;
                    op   = plain;
                    got  = 1'b1;
                end
            end
        endcase

        if (got)
            queue_token(kind, (kind == KIND_NUMBER) ? value : 32'd0, op, req.last_byte);
        else if (req.last_byte)
        begin
            // string ends inside a token: drop the partial token
            phase     = PH_IDLE;
            remaining = 3'd0;
            acc       = 32'd0;
            queue_token(KIND_END, 32'd0, 8'd0, 1'b1);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        csdd_out_t want;
        if (!rst_n)
        begin
            skip_cfg  = SKIP_RESET;
            key       = KEY_INIT;
            drop_left = 8'd0;
            phase     = PH_IDLE;
            lead      = 8'd0;
            acc       = 32'd0;
            remaining = 3'd0;
            failures  = 0;
            expected_tokens.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == SKIP_ADDR)
                skip_cfg = pwdata[7:0];

            // compare the token before taking the byte of this edge
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected token: kind %0d value %0d op %0d end %0b",
                                 token_data.token_kind, token_data.number_value,
                                 token_data.operator_code, token_data.string_end);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token_data.token_kind !== want.token_kind
                        || token_data.number_value !== want.number_value
                        || token_data.operator_code !== want.operator_code
                        || token_data.string_end !== want.string_end)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"token mismatch: kind %0d/%0d value %0d/%0d ",
                                      "op %0d/%0d end %0b/%0b (expected/actual)"},
                                     want.token_kind, token_data.token_kind,
                                     want.number_value, token_data.number_value,
                                     want.operator_code, token_data.operator_code,
                                     want.string_end, token_data.string_end);
                    end
                end
            end

            if (byte_valid && byte_ready)
                decode_byte(byte_data);
        end
        pending = expected_tokens.size();
    end

endmodule

@@ tb/tb_charstring_decrypt_decoder.sv @@
// Testbench top for the charstring decrypt decoder: clock, reset, APB writes of skip_count,
// encrypted byte stimulus and the token receiver; csdd_token_checker does the checking.
// Depends on csdd_pkg, charstring_decrypt_decoder and csdd_token_checker.
module tb_charstring_decrypt_decoder;
    import csdd_pkg::*;

    localparam logic [2:0] SKIP_ADDR = 3'({REG_SKIP_COUNT, 2'b00});

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    csdd_in_t    byte_data;
    logic        token_valid;
    logic        token_ready;
    csdd_out_t   token_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int failures;
    int pending;

    logic [15:0] cipher_key;
    bit          tx_burst;
    bit          tx_force_burst;
    bit          rx_burst;
    bit          hold_request;

    charstring_decrypt_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    csdd_token_checker token_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_data   (byte_data),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_data  (token_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .failures    (failures),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function int next_send_gap();
        if ($urandom_range(0, 29) == 0)
            tx_burst = !tx_burst;
        return (tx_burst || tx_force_burst) ? 0 : $urandom_range(0, 14);
    endfunction

    // Offer one request; return at the falling edge after it is taken, valid still high
    task automatic send_cipher(input logic [7:0] c, input logic first, input logic last);
        int gap;
        csdd_in_t req;
        gap = next_send_gap();
        if (first)
            cipher_key = KEY_INIT;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.cipher_byte  = c;
        req.string_start = first;
        req.last_byte    = last;
        byte_valid <= 1'b1;
        byte_data  <= req;
        cipher_key = ({8'd0, c} + cipher_key) * KEY_MUL + KEY_ADD;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_plain(input logic [7:0] p, input logic first, input logic last);
        if (first)
            cipher_key = KEY_INIT;
        send_cipher(p ^ cipher_key[15:8], first, last);
    endtask

    task automatic send_string(ref logic [7:0] body[$], input bit mark_last);
        foreach (body[i])
            send_plain(body[i], i == 0, mark_last && i == body.size() - 1);
    endtask

    function automatic void add_junk(ref logic [7:0] body[$], input int n);
        repeat (n) body.push_back(8'($urandom));
    endfunction

    function automatic void add_token(ref logic [7:0] body[$]);
        logic [7:0] op;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5:
                body.push_back(8'($urandom_range(32, 246)));
            6:
            begin
                body.push_back(8'($urandom_range(247, 250)));
                body.push_back(8'($urandom));
            end
            7:
            begin
                body.push_back(8'($urandom_range(251, 254)));
                body.push_back(8'($urandom));
            end
            8:
            begin
                body.push_back(CODE_LONG);
                add_junk(body, 4);
            end
            9:
            begin
                body.push_back(CODE_SHORT);
                add_junk(body, 2);
            end
            10, 11:
            begin
                body.push_back(CODE_ESCAPE);
                body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, 40)));
            end
            default:
            begin
                op = 8'($urandom_range(0, 31));
                if (op == CODE_ESCAPE || op == CODE_SHORT)
                    op = 8'd14;
                body.push_back(op);
            end
        endcase
    endfunction

    // One charstring with random tokens, now and then cut short, left open or trailed by noise
    task automatic random_charstring(input int skip, input bit allow_noise, output int sent);
        logic [7:0] body[$];
        int shape;
        int extra;
        body = {};
        extra = 0;
        add_junk(body, skip);
        repeat ($urandom_range(1, 10)) add_token(body);
        shape = $urandom_range(0, 9);
        if (shape <= 1)
            repeat ($urandom_range(1, 3))
                if (body.size() > skip + 1)
                    void'(body.pop_back());
        send_string(body, shape != 1);
        if (shape == 2)
        begin
            extra = $urandom_range(1, 4);
            for (int i = 0; i < extra; i++)
                send_plain(8'($urandom), 1'b0, i == extra - 1 && $urandom_range(0, 1) == 1);
        end
        else if (shape == 3 && allow_noise)
        begin
            extra = $urandom_range(1, 3);
            repeat (extra)
                send_cipher(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
        end
        sent = body.size() - skip + extra;
    endtask

    // Drop the last request off the bus and let everything drain
    task automatic wait_idle();
        byte_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_skip(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SKIP_ADDR;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Token receiver: random stall per request, with a long hold-off on demand
    initial
    begin
        int stall;
        token_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                token_ready <= 1'b0;
                repeat (80) @(negedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 29) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                token_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            token_ready <= 1'b1;
            @(posedge clk);
            while (!token_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [7:0] body[$];
        int skips[8];
        int count;
        int sent;
        int waited;
        rst_n          = 1'b0;
        byte_valid     = 1'b0;
        byte_data      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cipher_key     = KEY_INIT;
        tx_burst       = 1'b0;
        tx_force_burst = 1'b0;
        rx_burst       = 1'b0;
        hold_request   = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part at the reset skip count: every number form and operator class
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, 8'd32, 8'd246, 8'd247, 8'd0, 8'd250, 8'd255, 8'd251, 8'd0,
                8'd254, 8'd255, CODE_LONG, 8'h80, 8'h00, 8'h00, 8'h00,
                CODE_LONG, 8'h7F, 8'hFF, 8'hFF, 8'hFF, CODE_SHORT, 8'h80, 8'h00,
                CODE_SHORT, 8'h7F, 8'hFF, CODE_ESCAPE, 8'd0, CODE_ESCAPE, 8'd37,
                CODE_ESCAPE, 8'd19, CODE_ESCAPE, 8'd38, CODE_ESCAPE, 8'd255,
                8'd0, 8'd31, 8'd2, 8'd15, 8'd17, 8'd14};
        send_string(body, 1'b1);

        // strings that end inside a short, a long, a two-byte number and an escape
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, 8'd139, CODE_SHORT, 8'h12};
        send_string(body, 1'b1);
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, CODE_LONG, 8'd1};
        send_string(body, 1'b1);
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, 8'd248};
        send_string(body, 1'b1);
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, CODE_ESCAPE};
        send_string(body, 1'b1);

        // end on a dropped byte, also with first and last on one byte
        body = {};
        add_junk(body, 2);
        send_string(body, 1'b1);
        send_plain(8'($urandom), 1'b1, 1'b1);

        // open long number cut by a new first mark, then bytes after the end
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, CODE_LONG, 8'd1, 8'd2};
        send_string(body, 1'b0);
        body = {};
        add_junk(body, SKIP_RESET);
        body = {body, 8'd100, 8'd30};
        send_string(body, 1'b1);
        send_plain(8'd139, 1'b0, 1'b0);
        send_plain(8'd10, 1'b0, 1'b1);

        // Hold the receiver while numbers arrive back to back, so the input stalls
        wait_idle();
        hold_request   = 1'b1;
        tx_force_burst = 1'b1;
        body = {};
        add_junk(body, SKIP_RESET);
        repeat (30) body.push_back(8'($urandom_range(32, 246)));
        send_string(body, 1'b1);
        tx_force_burst = 1'b0;

        // Random part over several skip counts, extremes included
        skips = '{0, 255, 1, 9, 0, 2, 31, 4};
        skips[4] = $urandom_range(0, 12);
        foreach (skips[p])
        begin
            wait_idle();
            write_skip(8'(skips[p]));
            count = 0;
            do
            begin
                random_charstring(skips[p], skips[p] < 16, sent);
                count += sent;
            end
            while (skips[p] != 255 && count < 20);
        end
        byte_valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (20) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
